>>> sv/domq_pkg.sv
// Shared types, constants and codes for the deadline-ordered message queue.
package domq_pkg;

  localparam int unsigned DEPTH_DEF = 16;

  typedef enum logic [2:0] {
    KIND_PUSH_FRONT = 3'd0,
    KIND_PUSH_BACK  = 3'd1,
    KIND_INSERT     = 3'd2,
    KIND_POP        = 3'd3,
    KIND_CHECK      = 3'd4,
    KIND_ERASE      = 3'd5
  } kind_t;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_EMPTY     = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND = 2'd3;

  // Input transaction as held in the command queue.
  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] handle;
    logic [31:0] seq;
    logic [31:0] send_time;
    logic [31:0] timeout;
    logic [31:0] now_time;
  } cmd_t;

  // One result transaction, minus occupancy.
  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] handle;
    logic [31:0] seq;
    logic [31:0] send_time;
    logic [31:0] timeout;
    logic [31:0] assigned_seq;
    logic        expired;
  } res_t;

endpackage

>>> sv/domq_front.sv
// Front end: accepts input transactions into a two-entry command queue.
module domq_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  domq_pkg::cmd_t in_cmd,
  output logic           cmd_valid,
  input  logic           cmd_take,
  output domq_pkg::cmd_t cmd
);

  domq_pkg::cmd_t q_r [2];
  logic       rd_ptr_r, wr_ptr_r;
  logic [1:0] cnt_r;

  logic push, pop;

  assign in_ready  = (cnt_r != 2'd2);
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = q_r[rd_ptr_r];
  assign push      = in_valid && in_ready;
  assign pop       = cmd_valid && cmd_take;

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= in_cmd;
    end
    if (!rst_n) begin
      rd_ptr_r <= 1'b0;
      wr_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

>>> sv/domq_back.sv
// Back end: entry store, scan sequencer and result register.
module domq_back #(
  parameter int unsigned DEPTH = domq_pkg::DEPTH_DEF,
  localparam int unsigned IW = $clog2(DEPTH),
  localparam int unsigned CW = $clog2(DEPTH + 1)
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cmd_valid,
  output logic           cmd_take,
  input  domq_pkg::cmd_t cmd,
  output logic           res_valid,
  input  logic           res_ready,
  output domq_pkg::res_t res,
  output logic [CW-1:0]  res_occ
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SCAN  = 5'b00010,
    S_SHIFT = 5'b00100,
    S_DONE  = 5'b01000,
    S_OUT   = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  logic [15:0] e_handle_r [DEPTH];
  logic [31:0] e_seq_r    [DEPTH];
  logic [31:0] e_st_r     [DEPTH];
  logic [31:0] e_to_r     [DEPTH];

  logic [CW-1:0]  count_r, count_nxt;
  logic [31:0]    next_seq_r, next_seq_nxt;
  logic [CW-1:0]  idx_r, idx_nxt;   // scan position / insertion point
  domq_pkg::cmd_t c_r, c_nxt;
  domq_pkg::res_t res_r, res_nxt;
  logic [CW-1:0]  occ_r, occ_nxt;
  logic [31:0]    dl_r, dl_nxt;     // new entry deadline

  logic [IW-1:0] idx_i;
  logic [31:0]   head_dl, scan_dl;
  logic          full, is_ins;

  assign idx_i    = idx_r[IW-1:0];
  assign head_dl  = e_st_r[0] + e_to_r[0];
  assign scan_dl  = e_st_r[idx_i] + e_to_r[idx_i];
  assign full     = (count_r == CW'(DEPTH));
  assign is_ins   = (c_r.kind != domq_pkg::KIND_ERASE);
  assign cmd_take = (state_r == S_IDLE) && cmd_valid;
  assign res_valid = (state_r == S_OUT);
  assign res      = res_r;
  assign res_occ  = occ_r;

  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    next_seq_nxt = next_seq_r;
    idx_nxt      = idx_r;
    c_nxt        = c_r;
    res_nxt      = res_r;
    dl_nxt       = dl_r;
    occ_nxt      = occ_r;
    case (state_r)
      S_IDLE: begin
        if (cmd_valid) begin
          c_nxt     = cmd;
          dl_nxt    = cmd.send_time + cmd.timeout;
          idx_nxt   = '0;
          res_nxt   = '0;
          state_nxt = S_DONE;
          case (cmd.kind)
            domq_pkg::KIND_PUSH_FRONT, domq_pkg::KIND_PUSH_BACK,
            domq_pkg::KIND_INSERT: begin
              if (full) begin
                res_nxt.status = domq_pkg::ST_FULL;
              end else if (cmd.kind == domq_pkg::KIND_PUSH_FRONT) begin
                c_nxt.seq            = next_seq_r;
                res_nxt.assigned_seq = next_seq_r;
                next_seq_nxt         = next_seq_r + 32'd1;
                count_nxt            = count_r + 1'b1;
                state_nxt            = S_SHIFT;
              end else if (cmd.kind == domq_pkg::KIND_PUSH_BACK) begin
                idx_nxt   = count_r;
                count_nxt = count_r + 1'b1;
                state_nxt = S_SHIFT;
              end else begin
                state_nxt = S_SCAN;
              end
            end
            domq_pkg::KIND_POP: begin
              if (count_r == '0) begin
                res_nxt.status = domq_pkg::ST_EMPTY;
              end else begin
                res_nxt.handle    = e_handle_r[0];
                res_nxt.seq       = e_seq_r[0];
                res_nxt.send_time = e_st_r[0];
                res_nxt.timeout   = e_to_r[0];
                count_nxt         = count_r - 1'b1;
                c_nxt.kind        = domq_pkg::KIND_ERASE;
                state_nxt         = S_SHIFT;
              end
            end
            domq_pkg::KIND_CHECK: begin
              if (count_r == '0) res_nxt.status = domq_pkg::ST_EMPTY;
              else res_nxt.expired = (head_dl <= cmd.now_time);
            end
            domq_pkg::KIND_ERASE: state_nxt = S_SCAN;
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        // insert: stop at first deadline >= new; erase: stop at matching seq
        if (idx_r >= count_r) begin
          if (is_ins) begin
            count_nxt = count_r + 1'b1;
            state_nxt = S_SHIFT;
          end else begin
            res_nxt.status = domq_pkg::ST_NOT_FOUND;
            state_nxt      = S_DONE;
          end
        end else if (is_ins ? !(dl_r > scan_dl) : (e_seq_r[idx_i] == c_r.seq)) begin
          count_nxt = is_ins ? count_r + 1'b1 : count_r - 1'b1;
          state_nxt = S_SHIFT;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_SHIFT: state_nxt = S_DONE;
      S_DONE: begin
        occ_nxt   = count_r;
        state_nxt = S_OUT;
      end
      S_OUT:   if (res_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    c_r   <= c_nxt;
    res_r <= res_nxt;
    occ_r <= occ_nxt;
    dl_r  <= dl_nxt;
    if (state_r == S_SHIFT) begin
      for (int i = 0; i < DEPTH; i++) begin
        if (is_ins) begin
          if (CW'(i) == idx_r) begin
            e_handle_r[i] <= c_r.handle;
            e_seq_r[i]    <= c_r.seq;
            e_st_r[i]     <= c_r.send_time;
            e_to_r[i]     <= c_r.timeout;
          end else if (CW'(i) > idx_r && i > 0) begin
            e_handle_r[i] <= e_handle_r[i-1];
            e_seq_r[i]    <= e_seq_r[i-1];
            e_st_r[i]     <= e_st_r[i-1];
            e_to_r[i]     <= e_to_r[i-1];
          end
        end else if (CW'(i) >= idx_r && i + 1 < DEPTH) begin
          e_handle_r[i] <= e_handle_r[i+1];
          e_seq_r[i]    <= e_seq_r[i+1];
          e_st_r[i]     <= e_st_r[i+1];
          e_to_r[i]     <= e_to_r[i+1];
        end
      end
    end
    if (!rst_n) begin
      state_r    <= S_IDLE;
      count_r    <= '0;
      next_seq_r <= '0;
    end else begin
      state_r    <= state_nxt;
      count_r    <= count_nxt;
      next_seq_r <= next_seq_nxt;
    end
  end

endmodule

>>> sv/deadline_ordered_message_queue_top.sv
// Top level of the deadline-ordered message queue.
//
//  channel | dir | handshake            | payload
//  in_     | in  | in_tvalid/in_tready   | in_tuser kind, in_tdata fields
//  out_    | out | out_tvalid/out_tready | out_tuser status, out_tdata fields
//
// One transaction at a time in the back end: pop and push front/back pass the
// shift, done and output states, check and rejected commands only done and output;
// insert and erase first scan the store one entry a cycle. A two-entry command
// queue keeps accepting while the back end works. Reset (rst_n low, synchronous)
// empties the queue and clears the sequence counter. A stalled out_tready holds the result.
module deadline_ordered_message_queue_top #(
  parameter int unsigned DEPTH = domq_pkg::DEPTH_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [2:0]   in_tuser,   // kind
  input  logic [143:0] in_tdata,   // message_handle, message_seq, send_time, timeout, now_time
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [1:0]   out_tuser,  // status
  output logic [151:0] out_tdata   // out_handle, out_seq, out_send_time, out_timeout,
                                   // assigned_seq, expired, occupancy, zero pad
);

  localparam int unsigned CW = $clog2(DEPTH + 1);

  domq_pkg::cmd_t in_cmd, cmd;
  domq_pkg::res_t res;
  logic           cmd_valid, cmd_take;
  logic [CW-1:0]  occ;

  // Unpack the input transaction.
  assign in_cmd.kind      = in_tuser;
  assign in_cmd.handle    = in_tdata[15:0];
  assign in_cmd.seq       = in_tdata[47:16];
  assign in_cmd.send_time = in_tdata[79:48];
  assign in_cmd.timeout   = in_tdata[111:80];
  assign in_cmd.now_time  = in_tdata[143:112];

  domq_front u_front (
    .clk, .rst_n,
    .in_valid (in_tvalid), .in_ready (in_tready), .in_cmd,
    .cmd_valid, .cmd_take, .cmd
  );

  domq_back #(.DEPTH(DEPTH)) u_back (
    .clk, .rst_n,
    .cmd_valid, .cmd_take, .cmd,
    .res_valid (out_tvalid), .res_ready (out_tready), .res, .res_occ (occ)
  );

  // Pack the result transaction.
  assign out_tuser = res.status;
  assign out_tdata = {2'b0, 5'(occ), res.expired, res.assigned_seq, res.timeout,
                      res.send_time, res.seq, res.handle};

endmodule

>>> sv/domq_checker.sv
// Port-level checker for the deadline-ordered message queue.
module domq_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [1:0]   out_tuser,
  input logic [151:0] out_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  a_occ_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[149:145] <= 5'd16)
    else $error("occupancy out of range");

  a_expired_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != 2'd0 |-> !out_tdata[144])
    else $error("expired set with error status");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready |=> !out_tvalid)
    else $error("back-to-back results");

endmodule

bind deadline_ordered_message_queue_top domq_checker u_domq_checker (
  .clk, .rst_n, .out_tvalid, .out_tready, .out_tuser, .out_tdata
);
